// ===== src/lzwc_pkg.sv =====
`default_nettype none
package lzwc_pkg;

  localparam int DictSize = 4096;
  localparam int CodeLimit = (DictSize < 4096) ? DictSize : 4096;
  localparam int IdxW = $clog2(DictSize);
  localparam int CntW = IdxW + 1;
  localparam int CodeW = 12;
  localparam int SymW = 8;
  localparam int KeyW = CodeW + SymW;
  localparam int CfgIdxW = 3;
  localparam int NumSym = 6;

  localparam logic [CfgIdxW-1:0] REG_ALPHA = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_SYM0  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_SYM5  = 3'd6;

  typedef struct packed {
    logic [SymW-1:0] symbol;
    logic            end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [CodeW-1:0] code;
    logic             bad_symbol;
    logic             run_last;
  } out_item_t;

  // Classified item handed from the front part to the back part.
  typedef struct packed {
    logic [SymW-1:0]  symbol;
    logic [2:0]       sym_code;
    logic             found;
    logic             end_of_message;
  } cls_item_t;

endpackage
`default_nettype wire

// ===== src/lzwc_front.sv =====
`default_nettype none
module lzwc_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire lzwc_pkg::in_item_t            in_data,
  input  wire logic [2:0]                    alpha_n,
  input  wire logic [lzwc_pkg::NumSym-1:0][lzwc_pkg::SymW-1:0] syms,
  output logic                               q_valid,
  input  wire logic                          q_pop,
  output lzwc_pkg::cls_item_t                q_data
);

  // Two-entry queue of classified beats.
  lzwc_pkg::cls_item_t q_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       rd_r, rd_nxt;
  logic       wr_r, wr_nxt;
  lzwc_pkg::cls_item_t cls;
  logic push;

  always_comb begin
    cls.symbol = in_data.symbol;
    cls.end_of_message = in_data.end_of_message;
    cls.found = 1'b0;
    cls.sym_code = 3'd0;
    for (int i = lzwc_pkg::NumSym - 1; i >= 0; i--) begin
      if (3'(i) < alpha_n && syms[i] == in_data.symbol) begin
        cls.found = 1'b1;
        cls.sym_code = 3'(i);
      end
    end
  end

  assign in_stall = (cnt_r == 2'd2);
  assign push = in_valid && !in_stall;
  assign q_valid = (cnt_r != 2'd0);
  assign q_data = q_r[rd_r];

  always_comb begin
    cnt_nxt = cnt_r + 2'(push) - 2'(q_pop);
    rd_nxt = rd_r ^ q_pop;
    wr_nxt = wr_r ^ push;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      rd_r <= 1'b0;
      wr_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      rd_r <= rd_nxt;
      wr_r <= wr_nxt;
    end
    if (push) begin
      q_r[wr_r] <= cls;
    end
  end

endmodule
`default_nettype wire

// ===== src/lzwc_back.sv =====
`default_nettype none
module lzwc_back (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic [2:0]           alpha_n,
  input  wire logic                 q_valid,
  output logic                      q_pop,
  input  wire lzwc_pkg::cls_item_t  q_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output lzwc_pkg::out_item_t       out_data
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SCAN = 6'b000010,
    S_WAIT = 6'b000100,
    S_DEC  = 6'b001000,
    S_EMIT = 6'b010000,
    S_FIN  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic [lzwc_pkg::KeyW-1:0] mem [lzwc_pkg::DictSize];
  logic [lzwc_pkg::KeyW-1:0] rdata_r;
  logic [lzwc_pkg::CntW-1:0] ecnt_r, ecnt_nxt;
  logic [lzwc_pkg::CntW-1:0] k_r, k_nxt;
  logic [lzwc_pkg::CodeW-1:0] ph_r, ph_nxt;
  logic act_r, act_nxt;
  lzwc_pkg::cls_item_t it_r, it_nxt;
  logic [lzwc_pkg::KeyW-1:0] key;
  logic hit_r, hit_nxt;
  logic [lzwc_pkg::CntW-1:0] hitk_r, hitk_nxt;
  logic wr_en;
  logic [lzwc_pkg::CodeW-1:0] second_r, second_nxt;
  logic has2_r, has2_nxt;
  // First result of the item, held until the output register is free.
  lzwc_pkg::out_item_t f_r, f_nxt;
  lzwc_pkg::out_item_t o_r, o_nxt;
  logic ov_r, ov_nxt;
  logic [lzwc_pkg::CntW:0] tot;

  assign key = {ph_r, it_r.symbol};
  assign out_valid = ov_r;
  assign out_data = o_r;
  assign tot = (lzwc_pkg::CntW + 1)'(alpha_n) + {1'b0, ecnt_r};

  always_ff @(posedge clk) begin
    rdata_r <= mem[k_r[lzwc_pkg::IdxW-1:0]];
    if (wr_en) begin
      mem[ecnt_r[lzwc_pkg::IdxW-1:0]] <= key;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ecnt_nxt = ecnt_r;
    k_nxt = k_r;
    ph_nxt = ph_r;
    act_nxt = act_r;
    it_nxt = it_r;
    hit_nxt = hit_r;
    hitk_nxt = hitk_r;
    second_nxt = second_r;
    has2_nxt = has2_r;
    f_nxt = f_r;
    o_nxt = o_r;
    ov_nxt = ov_r && out_stall;
    q_pop = 1'b0;
    wr_en = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          it_nxt = q_data;
          k_nxt = '0;
          hit_nxt = 1'b0;
          state_nxt = (q_data.found && act_r) ? S_SCAN : S_DEC;
        end
      end
      S_SCAN: begin
        // Read one entry here; S_WAIT compares it in the next cycle.
        if (k_r < ecnt_r) begin
          k_nxt = k_r + 1'b1;
          state_nxt = S_WAIT;
        end else begin
          state_nxt = S_DEC;
        end
      end
      S_WAIT: begin
        if (rdata_r == key) begin
          hit_nxt = 1'b1;
          hitk_nxt = k_r - 1'b1;
          state_nxt = S_DEC;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_DEC: begin
        has2_nxt = 1'b0;
        f_nxt.bad_symbol = 1'b0;
        f_nxt.code = '0;
        f_nxt.run_last = 1'b0;
        state_nxt = S_EMIT;
        if (!it_r.found) begin
          f_nxt.bad_symbol = 1'b1;
          if (it_r.end_of_message && act_r) begin
            has2_nxt = 1'b1;
            second_nxt = ph_r;
          end
        end else if (!act_r) begin
          ph_nxt = lzwc_pkg::CodeW'(it_r.sym_code);
          act_nxt = 1'b1;
          state_nxt = S_FIN;
          if (it_r.end_of_message) begin
            f_nxt.code = lzwc_pkg::CodeW'(it_r.sym_code);
            state_nxt = S_EMIT;
          end
        end else if (hit_r) begin
          ph_nxt = lzwc_pkg::CodeW'((lzwc_pkg::CntW + 1)'(alpha_n) + {1'b0, hitk_r});
          state_nxt = S_FIN;
          if (it_r.end_of_message) begin
            f_nxt.code = ph_nxt;
            state_nxt = S_EMIT;
          end
        end else begin
          f_nxt.code = ph_r;
          if (tot < (lzwc_pkg::CntW + 1)'(lzwc_pkg::CodeLimit)) begin
            wr_en = 1'b1;
            ecnt_nxt = ecnt_r + 1'b1;
          end
          ph_nxt = lzwc_pkg::CodeW'(it_r.sym_code);
          if (it_r.end_of_message) begin
            has2_nxt = 1'b1;
            second_nxt = lzwc_pkg::CodeW'(it_r.sym_code);
          end
        end
        if (state_nxt == S_EMIT) begin
          f_nxt.run_last = !has2_nxt;
        end
      end
      S_EMIT: begin
        // The output register takes the first result once it is free.
        if (!ov_r || !out_stall) begin
          ov_nxt = 1'b1;
          o_nxt = f_r;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (has2_r) begin
          if (!ov_r || !out_stall) begin
            ov_nxt = 1'b1;
            o_nxt.code = second_r;
            o_nxt.bad_symbol = 1'b0;
            o_nxt.run_last = 1'b1;
            has2_nxt = 1'b0;
          end
        end else begin
          if (it_r.end_of_message) begin
            ecnt_nxt = '0;
            ph_nxt = '0;
            act_nxt = 1'b0;
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ecnt_r <= '0;
      ph_r <= '0;
      act_r <= 1'b0;
      ov_r <= 1'b0;
      has2_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ecnt_r <= ecnt_nxt;
      ph_r <= ph_nxt;
      act_r <= act_nxt;
      ov_r <= ov_nxt;
      has2_r <= has2_nxt;
    end
    k_r <= k_nxt;
    it_r <= it_nxt;
    hit_r <= hit_nxt;
    hitk_r <= hitk_nxt;
    second_r <= second_nxt;
    f_r <= f_nxt;
    o_r <= o_nxt;
  end

endmodule
`default_nettype wire

// ===== src/lzw_compress_small_alphabet_core.sv =====
`default_nettype none
// LZW compressor over a configurable alphabet of up to six byte symbols.
// One beat on the input carries a byte and an end-of-message flag; each beat
// yields zero, one or two result beats, the last marked by run_last. A front
// part matches the byte against the alphabet registers combinationally and
// queues it in a two-entry buffer; the back part then searches the learned
// dictionary held in a memory, one entry at a time (read, then compare). A
// miss scans every learned entry, and a waiting result is held while the
// receiver stalls. At most 4095 pairs are learned, which bounds the search.
// Write configuration only while idle.
module lzw_compress_small_alphabet_core (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire lzwc_pkg::in_item_t    in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output lzwc_pkg::out_item_t        out_data,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [lzwc_pkg::CfgIdxW-1:0] cfg_index,
  input  wire logic [7:0]            cfg_data
);

  logic [2:0] alpha_r;
  logic [lzwc_pkg::NumSym-1:0][lzwc_pkg::SymW-1:0] syms_r;
  logic [2:0] alpha_n;
  logic q_valid, q_pop;
  lzwc_pkg::cls_item_t q_data;

  assign cfg_ready = 1'b1;

  // Zero acts as one and seven acts as six.
  always_comb begin
    alpha_n = alpha_r;
    if (alpha_r == 3'd0) alpha_n = 3'd1;
    if (alpha_r == 3'd7) alpha_n = 3'd6;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= 3'd5;
      syms_r[0] <= 8'd32;
      syms_r[1] <= 8'd115;
      syms_r[2] <= 8'd102;
      syms_r[3] <= 8'd100;
      syms_r[4] <= 8'd103;
      syms_r[5] <= 8'd0;
    end else if (cfg_valid) begin
      if (cfg_index == lzwc_pkg::REG_ALPHA) begin
        alpha_r <= cfg_data[2:0];
      end else if (cfg_index <= lzwc_pkg::REG_SYM5) begin
        syms_r[cfg_index - lzwc_pkg::REG_SYM0] <= cfg_data;
      end
    end
  end

  lzwc_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .alpha_n(alpha_n), .syms(syms_r),
    .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data)
  );

  lzwc_back u_back (
    .clk(clk), .rst_n(rst_n), .alpha_n(alpha_n),
    .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

endmodule
`default_nettype wire

// ===== tb/lzw_checker.sv =====
`timescale 1ns / 100ps
// Watches the three channels of the LZW core, keeps its own copy of the
// dictionary state and compares every emitted code beat with the oldest
// predicted one.
module lzw_checker (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  input  wire logic                         in_stall,
  input  wire lzwc_pkg::in_item_t           in_data,
  input  wire logic                         out_valid,
  input  wire logic                         out_stall,
  input  wire lzwc_pkg::out_item_t          out_data,
  input  wire logic                         cfg_valid,
  input  wire logic                         cfg_ready,
  input  wire logic [lzwc_pkg::CfgIdxW-1:0] cfg_index,
  input  wire logic [7:0]                   cfg_data,
  output int                                fail_count,
  output int                                pending
);

  logic [lzwc_pkg::KeyW-1:0]  learned_pairs [lzwc_pkg::DictSize];
  logic [lzwc_pkg::CntW-1:0]  learned_cnt;
  logic [lzwc_pkg::CodeW-1:0] phrase;
  bit                         phrase_held;
  logic [2:0]                 alpha_reg;
  logic [lzwc_pkg::SymW-1:0]  sym_reg [lzwc_pkg::NumSym];
  lzwc_pkg::out_item_t        codes_due [$];

  function automatic int unsigned alpha_size(logic [2:0] raw);
    if (raw == 3'd0) return 1;
    if (raw > 3'd6) return 6;
    return raw;
  endfunction

  task automatic push_code(logic [lzwc_pkg::CodeW-1:0] code, logic bad);
    lzwc_pkg::out_item_t r;
    r.code = code;
    r.bad_symbol = bad;
    r.run_last = 1'b0;
    codes_due.insert(codes_due.size(), r);
  endtask

  // One accepted byte: classify it, then grow or close the current phrase.
  task automatic compress_byte(lzwc_pkg::in_item_t it);
    int unsigned n;
    int unsigned k;
    int unsigned first;
    logic [2:0] sym_code;
    bit found;
    bit hit;
    logic [lzwc_pkg::KeyW-1:0] key;
    n = alpha_size(alpha_reg);
    first = codes_due.size();
    found = 0;
    hit = 0;
    sym_code = '0;
    for (int i = n - 1; i >= 0; i--) begin
      if (sym_reg[i] == it.symbol) begin
        sym_code = 3'(i);
        found = 1;
      end
    end
    if (!found) begin
      push_code('0, 1'b1);
    end else if (!phrase_held) begin
      phrase = lzwc_pkg::CodeW'(sym_code);
      phrase_held = 1;
    end else begin
      key = {phrase, it.symbol};
      for (k = 0; k < learned_cnt; k++) begin
        if (learned_pairs[k] == key) begin
          hit = 1;
          break;
        end
      end
      if (hit) begin
        phrase = lzwc_pkg::CodeW'(n + k);
      end else begin
        push_code(phrase, 1'b0);
        if (n + learned_cnt < lzwc_pkg::CodeLimit && learned_cnt < lzwc_pkg::DictSize) begin
          learned_pairs[learned_cnt] = key;
          learned_cnt++;
        end
        phrase = lzwc_pkg::CodeW'(sym_code);
      end
    end
    if (it.end_of_message) begin
      if (phrase_held) push_code(phrase, 1'b0);
      learned_cnt = '0;
      phrase = '0;
      phrase_held = 0;
    end
    if (codes_due.size() > first) codes_due[codes_due.size() - 1].run_last = 1'b1;
  endtask

  always @(posedge clk) begin
    lzwc_pkg::out_item_t want;
    if (!rst_n) begin
      learned_cnt = '0;
      phrase = '0;
      phrase_held = 0;
      alpha_reg = 3'd5;
      sym_reg[0] = 8'd32;
      sym_reg[1] = 8'd115;
      sym_reg[2] = 8'd102;
      sym_reg[3] = 8'd100;
      sym_reg[4] = 8'd103;
      sym_reg[5] = 8'd0;
      codes_due.delete();
      fail_count <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (codes_due.size() == 0) begin
          $error("unexpected result beat: code %0d bad_symbol %0b run_last %0b",
                 out_data.code, out_data.bad_symbol, out_data.run_last);
          fail_count <= fail_count + 1;
        end else begin
          want = codes_due.pop_front();
          if (out_data !== want) begin
            if (out_data.code !== want.code)
              $error("code: expected %0d, got %0d", want.code, out_data.code);
            if (out_data.bad_symbol !== want.bad_symbol)
              $error("bad_symbol: expected %0b, got %0b", want.bad_symbol,
                     out_data.bad_symbol);
            if (out_data.run_last !== want.run_last)
              $error("run_last: expected %0b, got %0b", want.run_last,
                     out_data.run_last);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == lzwc_pkg::REG_ALPHA) alpha_reg = cfg_data[2:0];
        else if (cfg_index <= lzwc_pkg::REG_SYM5)
          sym_reg[cfg_index - lzwc_pkg::REG_SYM0] = cfg_data;
      end
      if (in_valid && !in_stall) compress_byte(in_data);
    end
    pending <= codes_due.size();
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// Stimulus and verdict for the LZW core. The byte stream is mostly made of
// symbols from the current alphabet so that phrases really grow and the
// dictionary fills, with a sprinkling of foreign bytes and message ends.
// The run steps through six alphabet settings, each with a set pattern
// of sender gaps and receiver stalls.
module tb_top;

  localparam int QuietLimit = 50000;
  localparam int PhaseItems = 225;
  localparam int SettleCycles = 100;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  lzwc_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  lzwc_pkg::out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [lzwc_pkg::CfgIdxW-1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;
  int fail_count;
  int pending;

  // Gap percentages of the sender and the receiver for the current phase.
  int send_gap_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;
  int beats_sent = 0;

  // The testbench's own view of the alphabet, used to pick good bytes.
  logic [2:0] alpha_now = 3'd5;
  logic [7:0] alpha_syms [lzwc_pkg::NumSym] =
      '{8'd32, 8'd115, 8'd102, 8'd100, 8'd103, 8'd0};

  always #5 clk = ~clk;

  lzw_compress_small_alphabet_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  lzw_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  // The receiver decides afresh every cycle whether to hold off the next beat.
  always @(posedge clk) begin
    out_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
  end

  // The watchdog ends the run if no channel moves a beat for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
        $display("lzw_compress_small_alphabet_core test failed");
        $finish;
      end
    end
  end

  // The valid line is lowered only while idling, so a beat that follows
  // directly on another never sees two assignments in one time step.
  task automatic send_beat(logic [7:0] sym, logic eom);
    while (send_gap_pct > 0 && $urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{symbol: sym, end_of_message: eom};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [lzwc_pkg::CfgIdxW-1:0] idx, logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Loads a full alphabet setting; called only with the core idle.
  task automatic load_alphabet(logic [2:0] count, logic [7:0] s0, logic [7:0] s1,
                               logic [7:0] s2, logic [7:0] s3, logic [7:0] s4,
                               logic [7:0] s5);
    alpha_now = count;
    alpha_syms = '{s0, s1, s2, s3, s4, s5};
    write_reg(lzwc_pkg::REG_ALPHA, {5'd0, count});
    for (int i = 0; i < lzwc_pkg::NumSym; i++)
      write_reg(lzwc_pkg::REG_SYM0 + 3'(i), alpha_syms[i]);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Random bytes: mostly alphabet members so phrases grow, some foreign
  // bytes, and an occasional end of message to restart the dictionary.
  task automatic random_phase(int count);
    int unsigned n;
    int pause_at;
    logic [7:0] sym;
    n = (alpha_now == 3'd0) ? 1 : (alpha_now > 3'd6) ? 6 : alpha_now;
    pause_at = $urandom_range(count - 1);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 8) sym = 8'($urandom_range(255));
      else sym = alpha_syms[$urandom_range(n - 1)];
      send_beat(sym, $urandom_range(29) == 0);
      // Once per phase the sender holds back until every code is out.
      if (i == pause_at) wait_drained();
    end
    // Close the message so the next setting starts from an empty dictionary.
    send_beat(alpha_syms[0], 1'b1);
    wait_drained();
    repeat (SettleCycles) @(posedge clk);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed opening on the reset alphabet: repeated pairs that build
    // longer phrases, foreign bytes at both extremes in the middle of a
    // phrase, a foreign byte that ends a message with a phrase held, one
    // that ends it with nothing held, and a one-byte message.
    send_beat(8'd32, 1'b0);
    send_beat(8'd115, 1'b0);
    send_beat(8'd32, 1'b0);
    send_beat(8'd115, 1'b0);
    send_beat(8'd32, 1'b0);
    send_beat(8'd115, 1'b0);
    send_beat(8'd32, 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(8'd102, 1'b0);
    send_beat(8'd100, 1'b0);
    send_beat(8'd103, 1'b0);
    send_beat(8'd103, 1'b0);
    send_beat(8'd200, 1'b1);
    send_beat(8'd1, 1'b1);
    send_beat(8'd103, 1'b1);
    send_beat(8'd115, 1'b0);
    send_beat(8'd115, 1'b0);
    send_beat(8'd115, 1'b1);
    wait_drained();
    repeat (SettleCycles) @(posedge clk);

    // Phase 0: reset alphabet, no idling on either side.
    send_gap_pct = 0;
    recv_stall_pct = 0;
    random_phase(PhaseItems);

    // Phase 1: a single symbol, byte zero, with sender gaps.
    load_alphabet(3'd1, 8'h00, 8'h11, 8'h22, 8'h33, 8'h44, 8'h55);
    send_gap_pct = 58;
    random_phase(PhaseItems);

    // Phase 2: six symbols with a repeated byte; the lowest code must win.
    load_alphabet(3'd6, 8'hFF, 8'h00, 8'hAA, 8'h55, 8'hFF, 8'h0F);
    send_gap_pct = 0;
    recv_stall_pct = 58;
    random_phase(PhaseItems);

    // Phase 3: a count of zero behaves as one.
    load_alphabet(3'd0, 8'h7E, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05);
    send_gap_pct = 21;
    recv_stall_pct = 21;
    random_phase(PhaseItems);

    // Phase 4: a count of seven behaves as six.
    load_alphabet(3'd7, 8'd1, 8'd2, 8'd4, 8'd8, 8'd16, 8'd128);
    send_gap_pct = 58;
    recv_stall_pct = 0;
    random_phase(PhaseItems);

    // Phase 5: three of the usual symbols, receiver stalling.
    load_alphabet(3'd3, 8'd32, 8'd115, 8'd102, 8'd100, 8'd103, 8'd0);
    send_gap_pct = 0;
    recv_stall_pct = 58;
    random_phase(PhaseItems);

    recv_stall_pct = 0;
    repeat (SettleCycles) @(posedge clk);

    $display("Covered %0d input beats over six alphabet settings (counts 0, 1, 3, 5, 6, 7)",
             beats_sent);
    $display("with free-running, sender-gap, receiver-stall and mixed idling phases.");
    if (fail_count == 0 && pending == 0) begin
      $display("lzw_compress_small_alphabet_core test passed");
    end else begin
      $display("lzw_compress_small_alphabet_core test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/lzwc_pkg.sv
src/lzwc_front.sv
src/lzwc_back.sv
src/lzw_compress_small_alphabet_core.sv
tb/lzw_checker.sv
tb/tb_top.sv
